>>> hw/rtl/vrp_pkg.sv
// Shared widths, register indexes, payload types and rounding helpers for the vertex projector.
`default_nettype none

package vrp_pkg;

   // Field widths.
   localparam int unsigned CoordW   = 32;
   localparam int unsigned CoefW    = 16;
   localparam int unsigned ZoomW    = 31;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 32;

   // Rotation arithmetic: Q1.14 coefficients, 48-bit products, 49-bit sums.
   localparam int unsigned CoefFrac  = 14;
   localparam int unsigned ProdW     = CoordW + CoefW;
   localparam int unsigned SumW      = ProdW + 1;
   localparam int unsigned ShiftW    = SumW - CoefFrac;
   localparam int unsigned RoundBias = 1 << (CoefFrac - 1);

   // Integer parts of the register reset values, scaled by the fraction width at the top.
   localparam int unsigned ZoomResetInt  = 20;
   localparam int unsigned DepthResetInt = 4;
   localparam int unsigned CoefOne       = 1 << CoefFrac;

   // Saturation limits of a coordinate.
   localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
   localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

   // Register indexes.
   typedef logic [CsrIdxW-1:0] csr_index_type;
   localparam csr_index_type CSR_COS_X = 3'd0;
   localparam csr_index_type CSR_SIN_X = 3'd1;
   localparam csr_index_type CSR_COS_Y = 3'd2;
   localparam csr_index_type CSR_SIN_Y = 3'd3;
   localparam csr_index_type CSR_ZOOM  = 3'd4;
   localparam csr_index_type CSR_DEPTH = 3'd5;

   // Configuration register set.
   typedef struct packed {
      logic signed [CoefW-1:0]  cos_x;
      logic signed [CoefW-1:0]  sin_x;
      logic signed [CoefW-1:0]  cos_y;
      logic signed [CoefW-1:0]  sin_y;
      logic [ZoomW-1:0]         zoom;
      logic signed [CoordW-1:0] depth;
   } cfg_type;

   // One result transaction.
   typedef struct packed {
      logic signed [CoordW-1:0] screen_x;
      logic signed [CoordW-1:0] screen_y;
      logic                     zero_depth;
      logic                     clipped;
   } rsp_data_type;

   // A saturated coordinate and its overflow flag.
   typedef struct packed {
      logic signed [CoordW-1:0] val;
      logic                     sat;
   } sat_type;

   // Round half up by the coefficient fraction, then clamp to a 32-bit coordinate.
   function automatic sat_type round_sat(input logic signed [SumW-1:0] sum);
      logic signed [SumW-1:0]   biased;
      logic signed [ShiftW-1:0] shifted;
      sat_type                  res;
      biased  = sum + SumW'(RoundBias);
      shifted = $signed(biased[SumW-1:CoefFrac]);
      res.sat = (shifted[ShiftW-1:CoordW-1] != {(ShiftW-CoordW+1){1'b0}}) &&
                (shifted[ShiftW-1:CoordW-1] != {(ShiftW-CoordW+1){1'b1}});
      if (!res.sat) begin
         res.val = shifted[CoordW-1:0];
      end else if (shifted[ShiftW-1]) begin
         res.val = CoordMin;
      end else begin
         res.val = CoordMax;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vrp_if.sv
// Channel interfaces of the vertex projector: vertex input, result output, register writes.
`default_nettype none

interface vrp_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [vrp_pkg::CoordW-1:0] pos_x;
   logic signed [vrp_pkg::CoordW-1:0] pos_y;
   logic signed [vrp_pkg::CoordW-1:0] pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface vrp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [vrp_pkg::CoordW-1:0] screen_x;
   logic signed [vrp_pkg::CoordW-1:0] screen_y;
   logic                              zero_depth;
   logic                              clipped;

   modport source (output valid, output screen_x, output screen_y, output zero_depth,
                   output clipped, input ready);
   modport sink   (input valid, input screen_x, input screen_y, input zero_depth,
                   input clipped, output ready);
endinterface

interface vrp_csr_if;
   logic                         valid;
   logic                         ready;
   logic [vrp_pkg::CsrIdxW-1:0]  index;
   logic [vrp_pkg::CsrDataW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/vrp_rotate.sv
// Two-stage planar rotation: p = a*c - b*s and q = a*s + b*c, rounded and saturated.
`default_nettype none

module vrp_rotate (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [vrp_pkg::CoordW-1:0] a,
   input  logic signed [vrp_pkg::CoordW-1:0] b,
   input  logic signed [vrp_pkg::CoefW-1:0]  c,
   input  logic signed [vrp_pkg::CoefW-1:0]  s,
   input  logic [vrp_pkg::CoordW-1:0]        pass_in,
   input  logic                              clip_in,
   output logic                              out_valid,
   output logic signed [vrp_pkg::CoordW-1:0] p,
   output logic signed [vrp_pkg::CoordW-1:0] q,
   output logic [vrp_pkg::CoordW-1:0]        pass_out,
   output logic                              clip_out
);

   localparam int unsigned SumW = vrp_pkg::SumW;

   logic                              mul_valid_ff;
   logic signed [vrp_pkg::ProdW-1:0]  prod_ac_ff, prod_ac_in;
   logic signed [vrp_pkg::ProdW-1:0]  prod_bs_ff, prod_bs_in;
   logic signed [vrp_pkg::ProdW-1:0]  prod_as_ff, prod_as_in;
   logic signed [vrp_pkg::ProdW-1:0]  prod_bc_ff, prod_bc_in;
   logic [vrp_pkg::CoordW-1:0]        pass_m_ff;
   logic                              clip_m_ff;

   logic                              sum_valid_ff;
   logic signed [vrp_pkg::SumW-1:0]   sum_p, sum_q;
   vrp_pkg::sat_type                  sat_p, sat_q;
   logic signed [vrp_pkg::CoordW-1:0] p_ff;
   logic signed [vrp_pkg::CoordW-1:0] q_ff;
   logic [vrp_pkg::CoordW-1:0]        pass_s_ff;
   logic                              clip_s_ff, clip_s_in;

   // Multiply stage: the four partial products.
   assign prod_ac_in = a * c;
   assign prod_bs_in = b * s;
   assign prod_as_in = a * s;
   assign prod_bc_in = b * c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ac_ff <= prod_ac_in;
         prod_bs_ff <= prod_bs_in;
         prod_as_ff <= prod_as_in;
         prod_bc_ff <= prod_bc_in;
         pass_m_ff  <= pass_in;
         clip_m_ff  <= clip_in;
      end
   end

   // Sum stage: combine, round half up, saturate, and accumulate the clip flag.
   assign sum_p     = SumW'(prod_ac_ff) - SumW'(prod_bs_ff);
   assign sum_q     = SumW'(prod_as_ff) + SumW'(prod_bc_ff);
   assign sat_p     = vrp_pkg::round_sat(sum_p);
   assign sat_q     = vrp_pkg::round_sat(sum_q);
   assign clip_s_in = clip_m_ff | sat_p.sat | sat_q.sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (en) begin
         sum_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff      <= sat_p.val;
         q_ff      <= sat_q.val;
         pass_s_ff <= pass_m_ff;
         clip_s_ff <= clip_s_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign p         = p_ff;
   assign q         = q_ff;
   assign pass_out  = pass_s_ff;
   assign clip_out  = clip_s_ff;

endmodule

`default_nettype wire

>>> hw/rtl/vrp_project.sv
// Perspective stage: depth offset, zoom products, pipelined restoring divide and saturation.
`default_nettype none

module vrp_project (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [vrp_pkg::CoordW-1:0] x2,
   input  logic signed [vrp_pkg::CoordW-1:0] y1,
   input  logic signed [vrp_pkg::CoordW-1:0] z2,
   input  logic                              clip_in,
   input  logic [vrp_pkg::ZoomW-1:0]         zoom,
   input  logic signed [vrp_pkg::CoordW-1:0] depth,
   output logic                              out_valid,
   output vrp_pkg::rsp_data_type             out_data
);

   localparam int unsigned CoordW        = vrp_pkg::CoordW;
   localparam int unsigned DepW          = CoordW + 1;
   localparam int unsigned NumW          = 2 * CoordW;
   localparam int unsigned MagW          = NumW - 1;
   localparam int unsigned QuoW          = CoordW + 1;
   localparam int unsigned HiW           = MagW - QuoW;
   localparam int unsigned StepsPerStage = 3;
   localparam int unsigned DivStages     = QuoW / StepsPerStage;

   // Per-lane divider state: partial remainder, dividend bits turning into quotient bits.
   typedef struct packed {
      logic [QuoW-1:0] rem;
      logic [QuoW-1:0] quo;
      logic            ovf;
      logic            neg;
   } lane_type;

   // Fields shared by both lanes.
   typedef struct packed {
      logic [DepW-1:0] dmag;
      logic            zero;
      logic            clip;
   } side_type;

   // One restoring division step.
   function automatic lane_type div_step(input lane_type l, input logic [DepW-1:0] d);
      logic [QuoW:0] trial;
      lane_type      res;
      res   = l;
      trial = {l.rem, l.quo[QuoW-1]};
      if (trial >= {1'b0, d}) begin
         res.rem = QuoW'(trial - {1'b0, d});
         res.quo = {l.quo[QuoW-2:0], 1'b1};
      end else begin
         res.rem = trial[QuoW-1:0];
         res.quo = {l.quo[QuoW-2:0], 1'b0};
      end
      return res;
   endfunction

   // Sign the magnitude quotient and clamp to a coordinate.
   function automatic vrp_pkg::sat_type finish(input lane_type l);
      logic [QuoW-1:0]  neg_q;
      vrp_pkg::sat_type res;
      neg_q = ~l.quo + QuoW'(1);
      if (!l.neg) begin
         res.sat = l.ovf || (l.quo > QuoW'(vrp_pkg::CoordMax));
         res.val = res.sat ? vrp_pkg::CoordMax : l.quo[CoordW-1:0];
      end else begin
         res.sat = l.ovf || (l.quo > {2'b01, {(QuoW-2){1'b0}}});
         res.val = res.sat ? vrp_pkg::CoordMin : neg_q[CoordW-1:0];
      end
      return res;
   endfunction

   // Stage 1: adjusted depth and zoom products.
   logic                    v1_ff;
   logic signed [DepW-1:0]  za_ff, za_in;
   logic signed [NumW-1:0]  nx_ff, nx_in;
   logic signed [NumW-1:0]  ny_ff, ny_in;
   logic                    clip1_ff;

   assign za_in = {z2[CoordW-1], z2} + {depth[CoordW-1], depth};
   assign nx_in = x2 * $signed({1'b0, zoom});
   assign ny_in = y1 * $signed({1'b0, zoom});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         za_ff    <= za_in;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         clip1_ff <= clip_in;
      end
   end

   // Stage 2: magnitudes and quotient signs.
   logic                v2_ff;
   logic [MagW-1:0]     nxmag_ff, nxmag_in;
   logic [MagW-1:0]     nymag_ff, nymag_in;
   logic                negx_ff, negy_ff;
   side_type            side2_ff, side2_in;
   logic [NumW-1:0]     nx_neg, ny_neg;
   logic [DepW-1:0]     za_neg;

   assign nx_neg         = -nx_ff;
   assign ny_neg         = -ny_ff;
   assign za_neg         = -za_ff;
   assign nxmag_in       = nx_ff[NumW-1] ? nx_neg[MagW-1:0] : nx_ff[MagW-1:0];
   assign nymag_in       = ny_ff[NumW-1] ? ny_neg[MagW-1:0] : ny_ff[MagW-1:0];
   assign side2_in.dmag  = za_ff[DepW-1] ? za_neg : za_ff;
   assign side2_in.zero  = (za_ff == '0);
   assign side2_in.clip  = clip1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nxmag_ff <= nxmag_in;
         nymag_ff <= nymag_in;
         negx_ff  <= nx_ff[NumW-1] ^ za_ff[DepW-1];
         negy_ff  <= ny_ff[NumW-1] ^ za_ff[DepW-1];
         side2_ff <= side2_in;
      end
   end

   // Stage 3: overflow precheck on the high dividend bits, divider setup.
   lane_type lane_x0_in, lane_y0_in;
   logic [QuoW-1:0] hix, hiy;

   assign hix = {{(QuoW-HiW){1'b0}}, nxmag_ff[MagW-1:QuoW]};
   assign hiy = {{(QuoW-HiW){1'b0}}, nymag_ff[MagW-1:QuoW]};

   always_comb begin
      lane_x0_in.ovf = (hix >= side2_ff.dmag);
      lane_x0_in.rem = lane_x0_in.ovf ? '0 : hix;
      lane_x0_in.quo = nxmag_ff[QuoW-1:0];
      lane_x0_in.neg = negx_ff;
      lane_y0_in.ovf = (hiy >= side2_ff.dmag);
      lane_y0_in.rem = lane_y0_in.ovf ? '0 : hiy;
      lane_y0_in.quo = nymag_ff[QuoW-1:0];
      lane_y0_in.neg = negy_ff;
   end

   // Divider stages, three quotient bits each.
   lane_type lane_x_ff [0:DivStages];
   lane_type lane_y_ff [0:DivStages];
   side_type side_ff   [0:DivStages];
   logic     vdiv_ff   [0:DivStages];
   lane_type lane_x_in [1:DivStages];
   lane_type lane_y_in [1:DivStages];

   always_comb begin
      for (int g = 1; g <= DivStages; g++) begin
         lane_x_in[g] = lane_x_ff[g-1];
         lane_y_in[g] = lane_y_ff[g-1];
         for (int k = 0; k < StepsPerStage; k++) begin
            lane_x_in[g] = div_step(lane_x_in[g], side_ff[g-1].dmag);
            lane_y_in[g] = div_step(lane_y_in[g], side_ff[g-1].dmag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g <= DivStages; g++) begin
            vdiv_ff[g] <= 1'b0;
         end
      end else if (en) begin
         vdiv_ff[0] <= v2_ff;
         for (int g = 1; g <= DivStages; g++) begin
            vdiv_ff[g] <= vdiv_ff[g-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_x_ff[0] <= lane_x0_in;
         lane_y_ff[0] <= lane_y0_in;
         side_ff[0]   <= side2_ff;
         for (int g = 1; g <= DivStages; g++) begin
            lane_x_ff[g] <= lane_x_in[g];
            lane_y_ff[g] <= lane_y_in[g];
            side_ff[g]   <= side_ff[g-1];
         end
      end
   end

   // Final stage: sign, saturation and the zero-depth override.
   logic                  vf_ff;
   vrp_pkg::rsp_data_type data_f_ff, data_f_in;
   vrp_pkg::sat_type      fin_x, fin_y;

   assign fin_x = finish(lane_x_ff[DivStages]);
   assign fin_y = finish(lane_y_ff[DivStages]);

   always_comb begin
      if (side_ff[DivStages].zero) begin
         data_f_in.screen_x   = '0;
         data_f_in.screen_y   = '0;
         data_f_in.zero_depth = 1'b1;
         data_f_in.clipped    = side_ff[DivStages].clip;
      end else begin
         data_f_in.screen_x   = fin_x.val;
         data_f_in.screen_y   = fin_y.val;
         data_f_in.zero_depth = 1'b0;
         data_f_in.clipped    = side_ff[DivStages].clip | fin_x.sat | fin_y.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else if (en) begin
         vf_ff <= vdiv_ff[DivStages];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_f_ff <= data_f_in;
      end
   end

   assign out_valid = vf_ff;
   assign out_data  = data_f_ff;

endmodule

`default_nettype wire

>>> hw/rtl/vertex_rotate_project.sv
// Top level of the vertex projector: registers, two rotations, projection and output register.
//
//   channel  direction  handshake               payload
//   req_chan in         valid/ready             pos_x, pos_y, pos_z
//   rsp_chan out        valid/ready             screen_x, screen_y, zero_depth, clipped
//   csr_chan in         valid/ready (ready = 1) index, data
//
// One transaction is accepted per cycle while the pipeline advances; its result passes
// through 20 register stages: four for the two rotations, two for the zoom products
// and magnitudes, twelve for the divider (setup plus 11 stages of three quotient bits),
// one for sign and saturation, and the output register.
// Reset clears every valid bit and loads the default rotation, zoom and depth offset.
// A stalled result holds in the output register; the pipeline stops only when its last
// stage also holds a result, so bubbles keep closing up while the output waits.
`default_nettype none

module vertex_rotate_project #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   vrp_req_if.sink    req_chan,
   vrp_rsp_if.source  rsp_chan,
   vrp_csr_if.sink    csr_chan
);

   localparam int unsigned CoordW = vrp_pkg::CoordW;
   localparam int unsigned CoefW  = vrp_pkg::CoefW;
   localparam int unsigned ZoomW  = vrp_pkg::ZoomW;

   // Configuration registers.
   vrp_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            vrp_pkg::CSR_COS_X: cfg_in.cos_x = csr_chan.data[CoefW-1:0];
            vrp_pkg::CSR_SIN_X: cfg_in.sin_x = csr_chan.data[CoefW-1:0];
            vrp_pkg::CSR_COS_Y: cfg_in.cos_y = csr_chan.data[CoefW-1:0];
            vrp_pkg::CSR_SIN_Y: cfg_in.sin_y = csr_chan.data[CoefW-1:0];
            vrp_pkg::CSR_ZOOM:  cfg_in.zoom  = csr_chan.data[ZoomW-1:0];
            vrp_pkg::CSR_DEPTH: cfg_in.depth = csr_chan.data[CoordW-1:0];
            default:            cfg_in       = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_x <= CoefW'(vrp_pkg::CoefOne);
         cfg_ff.sin_x <= '0;
         cfg_ff.cos_y <= CoefW'(vrp_pkg::CoefOne);
         cfg_ff.sin_y <= '0;
         cfg_ff.zoom  <= ZoomW'(vrp_pkg::ZoomResetInt << FRAC_BITS);
         cfg_ff.depth <= CoordW'(vrp_pkg::DepthResetInt << FRAC_BITS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_chan.ready = 1'b1;

   // Pipeline advance and output register control.
   logic                  out_load, pipe_en;
   logic                  proj_valid;
   vrp_pkg::rsp_data_type proj_data;
   logic                  rsp_valid_ff;
   vrp_pkg::rsp_data_type rsp_data_ff;

   assign out_load       = !rsp_valid_ff || rsp_chan.ready;
   assign pipe_en        = out_load || !proj_valid;
   assign req_chan.ready = pipe_en;

   // Rotation about X: y1 = y*cx - z*sx, z1 = y*sx + z*cx; x rides along.
   logic                     rx_valid, rx_clip;
   logic signed [CoordW-1:0] rx_y1, rx_z1;
   logic [CoordW-1:0]        rx_x;

   vrp_rotate u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_chan.valid),
      .a         (req_chan.pos_y),
      .b         (req_chan.pos_z),
      .c         (cfg_ff.cos_x),
      .s         (cfg_ff.sin_x),
      .pass_in   (req_chan.pos_x),
      .clip_in   (1'b0),
      .out_valid (rx_valid),
      .p         (rx_y1),
      .q         (rx_z1),
      .pass_out  (rx_x),
      .clip_out  (rx_clip)
   );

   // Rotation about Y: z2 = z1*cy - x*sy, x2 = z1*sy + x*cy; y1 rides along.
   logic                     ry_valid, ry_clip;
   logic signed [CoordW-1:0] ry_z2, ry_x2;
   logic [CoordW-1:0]        ry_y1;

   vrp_rotate u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (rx_valid),
      .a         (rx_z1),
      .b         ($signed(rx_x)),
      .c         (cfg_ff.cos_y),
      .s         (cfg_ff.sin_y),
      .pass_in   (rx_y1),
      .clip_in   (rx_clip),
      .out_valid (ry_valid),
      .p         (ry_z2),
      .q         (ry_x2),
      .pass_out  (ry_y1),
      .clip_out  (ry_clip)
   );

   // Perspective divide and zoom.
   vrp_project u_project (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (ry_valid),
      .x2        (ry_x2),
      .y1        ($signed(ry_y1)),
      .z2        (ry_z2),
      .clip_in   (ry_clip),
      .zoom      (cfg_ff.zoom),
      .depth     (cfg_ff.depth),
      .out_valid (proj_valid),
      .out_data  (proj_data)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= proj_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && proj_valid) begin
         rsp_data_ff <= proj_data;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.screen_x   = rsp_data_ff.screen_x;
   assign rsp_chan.screen_y   = rsp_data_ff.screen_y;
   assign rsp_chan.zero_depth = rsp_data_ff.zero_depth;
   assign rsp_chan.clipped    = rsp_data_ff.clipped;

endmodule

`default_nettype wire

>>> hw/rtl/vrp_check.sv
// Port-level checker for the vertex projector, bound to the top level.
`default_nettype none

module vrp_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [vrp_pkg::CoordW-1:0] screen_x,
   input logic signed [vrp_pkg::CoordW-1:0] screen_y,
   input logic                              zero_depth,
   input logic                              clipped
);

   // A stalled result transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   // A stalled result transaction keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(screen_x) && $stable(screen_y) &&
                                  $stable(zero_depth) && $stable(clipped))
      else $error("result payload changed while stalled");

   // A zero-depth result carries zero coordinates.
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && zero_depth |-> screen_x == '0 && screen_y == '0)
      else $error("zero-depth result with nonzero coordinates");

   // Reset empties the output.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind vertex_rotate_project vrp_check u_vrp_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .screen_x   (rsp_chan.screen_x),
   .screen_y   (rsp_chan.screen_y),
   .zero_depth (rsp_chan.zero_depth),
   .clipped    (rsp_chan.clipped)
);

`default_nettype wire

>>> tb/vertex_rotate_project_test.sv
// Self-checking testbench for the vertex projector: rotation, perspective divide and flags.
`timescale 1ns / 1ps

module vertex_rotate_project_test;

   localparam int ClockPeriod   = 10;
   localparam int TimeoutCycles = 200_000;
   localparam int FracBits      = 16;
   localparam int RandomPhases  = 12;
   localparam int VertsPerPhase = 111;
   localparam int SettleCycles  = 40;

   // Register indexes outside the map; writes to them must change nothing.
   localparam vrp_pkg::csr_index_type CSR_UNMAPPED_A = 3'd6;
   localparam vrp_pkg::csr_index_type CSR_UNMAPPED_B = 3'd7;

   localparam logic signed [vrp_pkg::CoordW-1:0] CoordTop    = vrp_pkg::CoordMax;
   localparam logic signed [vrp_pkg::CoordW-1:0] CoordBottom = vrp_pkg::CoordMin;
   localparam longint ClampHigh = vrp_pkg::CoordMax;
   localparam longint ClampLow  = vrp_pkg::CoordMin;

   typedef struct packed {
      logic signed [vrp_pkg::CoordW-1:0] x;
      logic signed [vrp_pkg::CoordW-1:0] y;
      logic signed [vrp_pkg::CoordW-1:0] z;
   } vertex_type;

   logic clock = 1'b0;
   logic reset;

   vrp_req_if req_chan ();
   vrp_rsp_if rsp_chan ();
   vrp_csr_if csr_chan ();

   vertex_rotate_project #(.FRAC_BITS(FracBits)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Vertices waiting to be sent, and projections waiting to come back.
   vertex_type            pending_vertices[$];
   vrp_pkg::rsp_data_type expected_points[$];

   // Register contents as the projector should hold them.
   vrp_pkg::cfg_type model_cfg;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;

   always #(ClockPeriod / 2) clock = ~clock;

   // Clamp to a 32-bit coordinate and note any overflow.
   function automatic longint clamp_coord(input longint value, inout logic clip);
      if (value > ClampHigh) begin
         clip = 1'b1;
         return ClampHigh;
      end
      if (value < ClampLow) begin
         clip = 1'b1;
         return ClampLow;
      end
      return value;
   endfunction

   // One rotated coordinate: two products, rounded half up by the Q1.14 shift.
   function automatic longint rotate_pair(input longint a, input longint ca,
                                          input longint b, input longint cb,
                                          inout logic clip);
      longint sum;
      sum = a * ca + b * cb + (longint'(1) << (vrp_pkg::CoefFrac - 1));
      return clamp_coord(sum >>> vrp_pkg::CoefFrac, clip);
   endfunction

   // Expected projection of one vertex under the current register values.
   function automatic vrp_pkg::rsp_data_type project_vertex(
         input logic signed [vrp_pkg::CoordW-1:0] px,
         input logic signed [vrp_pkg::CoordW-1:0] py,
         input logic signed [vrp_pkg::CoordW-1:0] pz);
      longint cx, sx, cy, sy, zm, y1, z1, x2, z2, za, sxv, syv;
      logic clip;
      vrp_pkg::rsp_data_type point;
      clip = 1'b0;
      cx   = $signed(model_cfg.cos_x);
      sx   = $signed(model_cfg.sin_x);
      cy   = $signed(model_cfg.cos_y);
      sy   = $signed(model_cfg.sin_y);
      zm   = model_cfg.zoom;

      // Rotate about X, then about Y using the rotated z.
      y1 = rotate_pair(py, cx, pz, -sx, clip);
      z1 = rotate_pair(py, sx, pz, cx, clip);
      x2 = rotate_pair(px, cy, z1, sy, clip);
      z2 = rotate_pair(z1, cy, px, -sy, clip);

      // Perspective divide; the quotient truncates toward zero.
      za = z2 + longint'($signed(model_cfg.depth));
      if (za == 0) begin
         sxv = 0;
         syv = 0;
         point.zero_depth = 1'b1;
      end else begin
         sxv = clamp_coord((x2 * zm) / za, clip);
         syv = clamp_coord((y1 * zm) / za, clip);
         point.zero_depth = 1'b0;
      end
      point.screen_x = sxv[vrp_pkg::CoordW-1:0];
      point.screen_y = syv[vrp_pkg::CoordW-1:0];
      point.clipped  = clip;
      return point;
   endfunction

   function automatic logic signed [vrp_pkg::CoordW-1:0] random_coord();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return int'($urandom_range(1 << 21)) - (1 << 20);
         5:             return int'($urandom_range(1 << 25)) - (1 << 24);
         6, 7:          return $urandom();
         8:             return int'($urandom_range(1 << 17)) - (1 << 16);
         default: begin
            case ($urandom_range(3))
               0:       return CoordTop;
               1:       return CoordBottom;
               2:       return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   // Coefficient word: mostly within one, sometimes the 16-bit extremes, junk above.
   function automatic logic [vrp_pkg::CsrDataW-1:0] random_coef_word();
      logic [vrp_pkg::CoefW-1:0] coef;
      case ($urandom_range(9))
         0:       coef = 16'h8000;
         1:       coef = 16'h7FFF;
         default: coef = 16'(int'($urandom_range(2 * vrp_pkg::CoefOne)) -
                             int'(vrp_pkg::CoefOne));
      endcase
      return {16'($urandom()), coef};
   endfunction

   task automatic queue_vertex(input logic signed [vrp_pkg::CoordW-1:0] x,
                               input logic signed [vrp_pkg::CoordW-1:0] y,
                               input logic signed [vrp_pkg::CoordW-1:0] z);
      pending_vertices.push_back('{x: x, y: y, z: z});
   endtask

   // Register write transaction; the local copy follows at the accepting edge.
   task automatic write_csr(input vrp_pkg::csr_index_type idx,
                            input logic [vrp_pkg::CsrDataW-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      case (idx)
         vrp_pkg::CSR_COS_X: model_cfg.cos_x = value[vrp_pkg::CoefW-1:0];
         vrp_pkg::CSR_SIN_X: model_cfg.sin_x = value[vrp_pkg::CoefW-1:0];
         vrp_pkg::CSR_COS_Y: model_cfg.cos_y = value[vrp_pkg::CoefW-1:0];
         vrp_pkg::CSR_SIN_Y: model_cfg.sin_y = value[vrp_pkg::CoefW-1:0];
         vrp_pkg::CSR_ZOOM:  model_cfg.zoom  = value[vrp_pkg::ZoomW-1:0];
         vrp_pkg::CSR_DEPTH: model_cfg.depth = value;
         default: ;
      endcase
      csr_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_all(input logic [vrp_pkg::CsrDataW-1:0] cx,
                              input logic [vrp_pkg::CsrDataW-1:0] sx,
                              input logic [vrp_pkg::CsrDataW-1:0] cy,
                              input logic [vrp_pkg::CsrDataW-1:0] sy,
                              input logic [vrp_pkg::CsrDataW-1:0] zm,
                              input logic [vrp_pkg::CsrDataW-1:0] dp);
      write_csr(vrp_pkg::CSR_COS_X, cx);
      write_csr(vrp_pkg::CSR_SIN_X, sx);
      write_csr(vrp_pkg::CSR_COS_Y, cy);
      write_csr(vrp_pkg::CSR_SIN_Y, sy);
      write_csr(vrp_pkg::CSR_ZOOM, zm);
      write_csr(vrp_pkg::CSR_DEPTH, dp);
   endtask

   // Block until every vertex is sent and every projection has come back.
   task automatic wait_until_idle();
      do @(negedge clock);
      while (pending_vertices.size() != 0 || req_chan.valid || expected_points.size() != 0);
   endtask

   task automatic check_field(input string what, input logic [vrp_pkg::CoordW-1:0] want,
                              input logic [vrp_pkg::CoordW-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // Vertex driver: predicts each accepted transaction, then offers the next one.
   always @(posedge clock) begin : drive_vertices
      vertex_type next_vertex;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_points.push_back(
               project_vertex(req_chan.pos_x, req_chan.pos_y, req_chan.pos_z));
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_vertex = pending_vertices.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.pos_x <= next_vertex.x;
               req_chan.pos_y <= next_vertex.y;
               req_chan.pos_z <= next_vertex.z;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each accepted transaction with the oldest prediction.
   always @(posedge clock) begin : check_points
      vrp_pkg::rsp_data_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h %h %b %b", $time,
                        rsp_chan.screen_x, rsp_chan.screen_y, rsp_chan.zero_depth,
                        rsp_chan.clipped);
               mismatch_count++;
            end else begin
               want = expected_points.pop_front();
               check_field("screen_x", want.screen_x, rsp_chan.screen_x);
               check_field("screen_y", want.screen_y, rsp_chan.screen_y);
               check_field("zero_depth", 32'(want.zero_depth), 32'(rsp_chan.zero_depth));
               check_field("clipped", 32'(want.clipped), 32'(rsp_chan.clipped));
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : run_test
      logic [vrp_pkg::CsrDataW-1:0] depth_word;
      logic [vrp_pkg::CsrDataW-1:0] zoom_word;
      logic signed [vrp_pkg::CoordW-1:0] vx, vy, vz;
      bit identity;

      // Known values on every input before the first edge.
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.pos_z = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data  = '0;

      model_cfg.cos_x = 16'(vrp_pkg::CoefOne);
      model_cfg.sin_x = '0;
      model_cfg.cos_y = 16'(vrp_pkg::CoefOne);
      model_cfg.sin_y = '0;
      model_cfg.zoom  = 31'(vrp_pkg::ZoomResetInt << FracBits);
      model_cfg.depth = 32'(vrp_pkg::DepthResetInt << FracBits);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: extremes, zero depth, and a divide by plus and minus one.
      queue_vertex(0, 0, 0);
      queue_vertex(CoordTop, CoordTop, CoordTop);
      queue_vertex(CoordBottom, CoordBottom, CoordBottom);
      queue_vertex(CoordTop, CoordBottom, -32'sd262144);
      queue_vertex(CoordTop, CoordBottom, -32'sd262143);
      queue_vertex(CoordBottom, CoordTop, -32'sd262145);
      queue_vertex(32'sd65536, -32'sd65536, 0);
      queue_vertex(-32'sd1, 32'sd1, CoordTop);
      wait_until_idle();

      // Most negative coefficients overflow the rotation; zoom of zero.
      program_all(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                  32'h0000_0000, 32'h7FFF_FFFF);
      queue_vertex(CoordTop, CoordTop, CoordTop);
      queue_vertex(CoordBottom, CoordBottom, CoordBottom);
      queue_vertex(CoordTop, CoordBottom, CoordTop);
      queue_vertex(0, 0, CoordBottom);
      wait_until_idle();

      // Largest coefficients and zoom, with junk in the unused upper data bits.
      program_all(32'hFFFF_7FFF, 32'hA5A5_7FFF, 32'h5A5A_7FFF, 32'hFFFF_8001,
                  32'hFFFF_FFFF, 32'h8000_0000);
      queue_vertex(CoordTop, CoordTop, CoordTop);
      queue_vertex(CoordBottom, CoordTop, CoordBottom);
      queue_vertex(32'sd65536, 32'sd131072, -32'sd65536);
      queue_vertex(-32'sd1, 0, 32'sd1);
      wait_until_idle();

      // Half turn about X, unit zoom, no depth offset; unmapped writes are ignored.
      program_all(32'h0000_C000, 32'h0000_0000, 32'h0000_4000, 32'h0000_0000,
                  32'h0001_0000, 32'h0000_0000);
      write_csr(CSR_UNMAPPED_A, 32'hFFFF_FFFF);
      write_csr(CSR_UNMAPPED_B, 32'h0000_0000);
      queue_vertex(32'sd65536, 32'sd131072, 32'sd65536);
      queue_vertex(0, 0, 0);
      queue_vertex(CoordTop, CoordBottom, 0);
      wait_until_idle();

      // Random settings per phase; each phase drains before the next is programmed.
      for (int phase = 0; phase < RandomPhases; phase++) begin
         identity = ($urandom_range(2) == 0);
         if ($urandom_range(9) < 7) begin
            depth_word = int'($urandom_range(1 << 23)) - (1 << 22);
         end else begin
            depth_word = $urandom();
         end
         case ($urandom_range(9))
            8:       zoom_word = $urandom();
            9:       zoom_word = $urandom_range(65535);
            default: zoom_word = $urandom_range(1 << 22, 1 << 16);
         endcase
         if (identity) begin
            program_all(32'(vrp_pkg::CoefOne), 32'h0, 32'(vrp_pkg::CoefOne), 32'h0,
                        zoom_word, depth_word);
         end else begin
            program_all(random_coef_word(), random_coef_word(), random_coef_word(),
                        random_coef_word(), zoom_word, depth_word);
         end

         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 47;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 47;
            end
            default: begin
               send_idle_pct  = 12;
               recv_stall_pct = 12;
            end
         endcase

         // A z that cancels the offset gives zero depth when the rotation is identity.
         repeat (VertsPerPhase) begin
            vx = random_coord();
            vy = random_coord();
            vz = random_coord();
            if ($urandom_range(15) == 0) begin
               vz = -$signed(depth_word);
            end
            queue_vertex(vx, vy, vz);
         end
         wait_until_idle();
      end

      repeat (SettleCycles) @(negedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Hard stop in case the projector hangs.
   initial begin : watchdog
      #(TimeoutCycles * ClockPeriod);
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/vrp_pkg.sv
hw/rtl/vrp_if.sv
hw/rtl/vrp_rotate.sv
hw/rtl/vrp_project.sv
hw/rtl/vertex_rotate_project.sv
hw/rtl/vrp_check.sv
tb/vertex_rotate_project_test.sv
